FILE: sv/three_wire_rtc_serial_master_assert.svh
// assertion macros for the three-wire rtc serial master
// no dependencies; included by the modules that check their own logic
`ifndef THREE_WIRE_RTC_SERIAL_MASTER_ASSERT_SVH
`define THREE_WIRE_RTC_SERIAL_MASTER_ASSERT_SVH

// same-cycle implication
`define TWRSM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TWRSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/twrsm_pkg.sv
// shared types and constants of the three-wire rtc serial master
// no dependencies; used by twrsm_front, twrsm_back and the top level
package twrsm_pkg;

   localparam int unsigned TIME_REG_COUNT = 7;
   localparam int unsigned TIME_BYTES     = 7;

   localparam logic [3:0] SET_FRAMES = 4'(TIME_REG_COUNT + 2);
   localparam logic [3:0] GET_FRAMES = 4'(TIME_REG_COUNT);
   localparam logic [3:0] ONE_FRAME  = 4'd1;

   localparam logic [7:0] WP_ADDR      = 8'h8e;
   localparam logic [7:0] WP_OFF       = 8'h00;
   localparam logic [7:0] WP_ON        = 8'h80;
   localparam logic [7:0] TIME_WR_BASE = 8'h80;
   localparam logic [7:0] READ_BIT     = 8'h01;
   localparam logic [7:0] TIME_RD_BASE = 8'h81 | READ_BIT;
   localparam logic [7:0] DATA_NONE    = 8'h00;
   localparam logic [7:0] HALF_RESET   = 8'd10;

   typedef enum logic [2:0] {
      OP_TICK  = 3'd0,
      OP_SET   = 3'd1,
      OP_GET   = 3'd2,
      OP_WRITE = 3'd3,
      OP_READ  = 3'd4
   } opcode_type;

   typedef enum logic [2:0] {
      KIND_NONE  = 3'd0,
      KIND_SET   = 3'd1,
      KIND_GET   = 3'd2,
      KIND_WRITE = 3'd3,
      KIND_READ  = 3'd4
   } cmd_kind_type;

   typedef enum logic [2:0] {
      PHASE_IDLE  = 3'd0,
      PHASE_SETUP = 3'd1,
      PHASE_WLOW  = 3'd2,
      PHASE_WHIGH = 3'd3,
      PHASE_RHIGH = 3'd4,
      PHASE_RLOW  = 3'd5,
      PHASE_END   = 3'd6
   } phase_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   reg_addr;
      logic [7:0]   write_data;
      logic [55:0]  time_in;
      logic         io_in;
   } entry_type;

endpackage

FILE: sv/twrsm_front.sv
// front end: takes each request, classifies the opcode and queues it
// depends on twrsm_pkg
module twrsm_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_opcode,
   input  logic [7:0]           req_reg_addr,
   input  logic [7:0]           req_write_data,
   input  logic [55:0]          req_time_in,
   input  logic                 req_io_in,
   output logic                 q_valid,
   output twrsm_pkg::entry_type q_entry,
   input  logic                 q_pop
);

   twrsm_pkg::entry_type entry_ff [2];
   twrsm_pkg::entry_type entry_in;
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;
   logic                 push;

   always_comb begin
      entry_in.reg_addr   = req_reg_addr;
      entry_in.write_data = req_write_data;
      entry_in.time_in    = req_time_in;
      entry_in.io_in      = req_io_in;
      unique case (req_opcode)
         twrsm_pkg::OP_SET:   entry_in.kind = twrsm_pkg::KIND_SET;
         twrsm_pkg::OP_GET:   entry_in.kind = twrsm_pkg::KIND_GET;
         twrsm_pkg::OP_WRITE: entry_in.kind = twrsm_pkg::KIND_WRITE;
         twrsm_pkg::OP_READ:  entry_in.kind = twrsm_pkg::KIND_READ;
         default:             entry_in.kind = twrsm_pkg::KIND_NONE;
      endcase
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_entry   = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
   assign count_in  = 2'(count_ff + {1'b0, push} - {1'b0, q_pop});

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

FILE: sv/twrsm_back.sv
// back end: frame sequencer that runs one tick per queued request and
// registers the pin levels and status; depends on twrsm_pkg and the assert header
`include "three_wire_rtc_serial_master_assert.svh"

module twrsm_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [7:0]           csr_write_data,
   input  logic                 q_valid,
   input  twrsm_pkg::entry_type q_entry,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_chip_enable,
   output logic                 rsp_serial_clock,
   output logic                 rsp_io_out,
   output logic                 rsp_io_drive,
   output logic                 rsp_busy_res,
   output logic                 rsp_done_res,
   output logic [7:0]           rsp_read_data,
   output logic [55:0]          rsp_time_out
);

   twrsm_pkg::phase_type    phase_ff, phase_in;
   twrsm_pkg::cmd_kind_type kind_ff, kind_in;
   logic [7:0]              tick_ff, tick_in;
   logic [4:0]              bit_ff, bit_in;
   logic [15:0]             shift_ff, shift_in;
   logic [3:0]              index_ff, index_in;
   logic [55:0]             tbuf_ff, tbuf_in;
   logic [7:0]              last_read_ff, last_read_in;
   logic [7:0]              half_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    ce_ff, sclk_ff, dout_ff, drv_ff, busy_ff, done_ff;
   logic                    ce, sclk, dout, drv, done;

   logic [7:0]              half_eff;
   logic                    half_end;
   logic                    read_kind;
   logic [4:0]              bit_next;
   logic [3:0]              index_next;
   logic [3:0]              frames;

   function automatic logic [15:0] frame_word(twrsm_pkg::cmd_kind_type kind,
                                              logic [3:0] idx, logic [55:0] tbuf);
      logic [2:0]  k;
      logic [15:0] word;
      k = 3'(idx - 4'd1);
      if (kind == twrsm_pkg::KIND_SET) begin
         if (idx == 4'd0) begin
            word = {twrsm_pkg::WP_OFF, twrsm_pkg::WP_ADDR};
         end else if (idx <= 4'(twrsm_pkg::TIME_REG_COUNT)) begin
            word = {tbuf[{k, 3'b000} +: 8], 8'(twrsm_pkg::TIME_WR_BASE + {4'b0, k, 1'b0})};
         end else begin
            word = {twrsm_pkg::WP_ON, twrsm_pkg::WP_ADDR};
         end
      end else begin
         k    = idx[2:0];
         word = {twrsm_pkg::DATA_NONE, 8'(twrsm_pkg::TIME_RD_BASE + {4'b0, k, 1'b0})};
      end
      return word;
   endfunction

   assign q_pop        = q_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = q_pop ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_comb begin
      phase_in     = phase_ff;
      kind_in      = kind_ff;
      tick_in      = tick_ff;
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      index_in     = index_ff;
      tbuf_in      = tbuf_ff;
      last_read_in = last_read_ff;
      done         = 1'b0;
      half_eff     = (half_ff == 8'd0) ? 8'd1 : half_ff;
      half_end     = ({1'b0, tick_ff} + 9'd1) >= {1'b0, half_eff};
      read_kind    = (kind_ff == twrsm_pkg::KIND_GET) || (kind_ff == twrsm_pkg::KIND_READ);
      bit_next     = bit_ff + 5'd1;
      index_next   = index_ff + 4'd1;
      frames       = (kind_ff == twrsm_pkg::KIND_SET) ? twrsm_pkg::SET_FRAMES :
                     (kind_ff == twrsm_pkg::KIND_GET) ? twrsm_pkg::GET_FRAMES :
                                                        twrsm_pkg::ONE_FRAME;

      if (phase_ff == twrsm_pkg::PHASE_IDLE) begin
         if (q_entry.kind != twrsm_pkg::KIND_NONE) begin
            kind_in  = q_entry.kind;
            index_in = 4'd0;
            bit_in   = 5'd0;
            tick_in  = 8'd0;
            phase_in = twrsm_pkg::PHASE_SETUP;
            unique case (q_entry.kind)
               twrsm_pkg::KIND_SET: begin
                  tbuf_in  = q_entry.time_in;
                  shift_in = frame_word(twrsm_pkg::KIND_SET, 4'd0, q_entry.time_in);
               end
               twrsm_pkg::KIND_GET: begin
                  tbuf_in  = '0;
                  shift_in = frame_word(twrsm_pkg::KIND_GET, 4'd0, '0);
               end
               twrsm_pkg::KIND_WRITE: begin
                  shift_in = {q_entry.write_data, q_entry.reg_addr};
               end
               default: begin
                  shift_in = {twrsm_pkg::DATA_NONE, q_entry.reg_addr};
               end
            endcase
         end
      end else if (!half_end) begin
         tick_in = tick_ff + 8'd1;
      end else begin
         tick_in = 8'd0;
         unique case (phase_ff)
            twrsm_pkg::PHASE_SETUP: phase_in = twrsm_pkg::PHASE_WLOW;
            twrsm_pkg::PHASE_WLOW:  phase_in = twrsm_pkg::PHASE_WHIGH;
            twrsm_pkg::PHASE_WHIGH: begin
               shift_in = {1'b0, shift_ff[15:1]};
               bit_in   = bit_next;
               if (bit_next == 5'd8 && read_kind) begin
                  phase_in = twrsm_pkg::PHASE_RHIGH;
               end else if (bit_next >= 5'd16) begin
                  phase_in = twrsm_pkg::PHASE_END;
               end else begin
                  phase_in = twrsm_pkg::PHASE_WLOW;
               end
            end
            twrsm_pkg::PHASE_RHIGH: phase_in = twrsm_pkg::PHASE_RLOW;
            twrsm_pkg::PHASE_RLOW: begin
               shift_in = {8'h00, q_entry.io_in, shift_ff[7:1]};
               bit_in   = bit_next;
               phase_in = (bit_next >= 5'd16) ? twrsm_pkg::PHASE_END : twrsm_pkg::PHASE_RHIGH;
            end
            twrsm_pkg::PHASE_END: begin
               if (kind_ff == twrsm_pkg::KIND_GET) begin
                  if (index_ff[2:0] < 3'(twrsm_pkg::TIME_BYTES)) begin
                     tbuf_in = tbuf_ff | (56'(shift_ff[7:0]) << {index_ff[2:0], 3'b000});
                  end
               end else if (kind_ff == twrsm_pkg::KIND_READ) begin
                  last_read_in = shift_ff[7:0];
               end
               index_in = index_next;
               bit_in   = 5'd0;
               if (index_next < frames) begin
                  shift_in = frame_word(kind_ff, index_next, tbuf_ff);
                  phase_in = twrsm_pkg::PHASE_SETUP;
               end else begin
                  phase_in = twrsm_pkg::PHASE_IDLE;
                  done     = 1'b1;
               end
            end
            default: phase_in = phase_ff;
         endcase
      end

      ce   = 1'b0;
      sclk = 1'b0;
      dout = 1'b0;
      drv  = 1'b0;
      unique case (phase_in)
         twrsm_pkg::PHASE_WLOW: begin
            ce   = 1'b1;
            drv  = 1'b1;
            dout = shift_in[0];
         end
         twrsm_pkg::PHASE_WHIGH: begin
            ce   = 1'b1;
            sclk = 1'b1;
            drv  = 1'b1;
            dout = shift_in[0];
         end
         twrsm_pkg::PHASE_RHIGH, twrsm_pkg::PHASE_END: begin
            ce   = 1'b1;
            sclk = 1'b1;
         end
         twrsm_pkg::PHASE_RLOW: ce = 1'b1;
         default: ce = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= twrsm_pkg::PHASE_IDLE;
         kind_ff      <= twrsm_pkg::KIND_NONE;
         tick_ff      <= 8'd0;
         bit_ff       <= 5'd0;
         shift_ff     <= 16'd0;
         index_ff     <= 4'd0;
         tbuf_ff      <= 56'd0;
         last_read_ff <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            phase_ff     <= phase_in;
            kind_ff      <= kind_in;
            tick_ff      <= tick_in;
            bit_ff       <= bit_in;
            shift_ff     <= shift_in;
            index_ff     <= index_in;
            tbuf_ff      <= tbuf_in;
            last_read_ff <= last_read_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= twrsm_pkg::HALF_RESET;
      end else if (csr_write_enable) begin
         half_ff <= csr_write_data;
      end
   end

   // result register, loaded on each tick taken from the queue
   always_ff @(posedge clock) begin
      if (q_pop) begin
         ce_ff   <= ce;
         sclk_ff <= sclk;
         dout_ff <= dout;
         drv_ff  <= drv;
         busy_ff <= (phase_in != twrsm_pkg::PHASE_IDLE);
         done_ff <= done;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chip_enable  = ce_ff;
   assign rsp_serial_clock = sclk_ff;
   assign rsp_io_out       = dout_ff;
   assign rsp_io_drive     = drv_ff;
   assign rsp_busy_res     = busy_ff;
   assign rsp_done_res     = done_ff;
   assign rsp_read_data    = last_read_ff;
   assign rsp_time_out     = tbuf_ff;

   `TWRSM_ASSERT_SAME(a_idle_counters, clock, reset, phase_ff == twrsm_pkg::PHASE_IDLE, bit_ff == 5'd0 && tick_ff == 8'd0, "idle with counters not cleared")
   `TWRSM_ASSERT_SAME(a_bit_range, clock, reset, 1'b1, bit_ff <= 5'd16, "bit count past sixteen")
   `TWRSM_ASSERT_SAME(a_done_idle, clock, reset, rsp_valid_ff && done_ff, !busy_ff && phase_ff == twrsm_pkg::PHASE_IDLE, "done while still busy")
   `TWRSM_ASSERT_SAME(a_enable_busy, clock, reset, rsp_valid_ff && ce_ff, busy_ff, "chip enable outside a command")
   `TWRSM_ASSERT_NEXT(a_hold_no_pop, clock, reset, !q_pop, $stable(phase_ff) && $stable(shift_ff), "sequencer moved without a tick")

endmodule

FILE: sv/three_wire_rtc_serial_master.sv
// Three-wire rtc serial master. Every request is one timing tick and yields
// exactly one response carrying the pin levels and status after that tick.
// One request is taken per clock and one response leaves per clock while
// rsp_ready is high: a tick enters a two-entry queue, the frame sequencer
// takes it from the queue in the next cycle, and its response is loaded
// into the output register, so throughput is one tick per cycle. Opcodes
// arriving while busy are dropped; half_bit_ticks must be written through csr_
// only while no command runs, which the block does not enforce; a value of
// zero acts as one.
// Depends on twrsm_pkg, twrsm_front and twrsm_back.
module three_wire_rtc_serial_master (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_reg_addr,
   input  logic [7:0]  req_write_data,
   input  logic [55:0] req_time_in,
   input  logic        req_io_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_chip_enable,
   output logic        rsp_serial_clock,
   output logic        rsp_io_out,
   output logic        rsp_io_drive,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [7:0]  rsp_read_data,
   output logic [55:0] rsp_time_out,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);

   logic                 q_valid;
   logic                 q_pop;
   twrsm_pkg::entry_type q_entry;

   twrsm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_reg_addr   (req_reg_addr),
      .req_write_data (req_write_data),
      .req_time_in    (req_time_in),
      .req_io_in      (req_io_in),
      .q_valid        (q_valid),
      .q_entry        (q_entry),
      .q_pop          (q_pop)
   );

   twrsm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_valid          (q_valid),
      .q_entry          (q_entry),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_chip_enable  (rsp_chip_enable),
      .rsp_serial_clock (rsp_serial_clock),
      .rsp_io_out       (rsp_io_out),
      .rsp_io_drive     (rsp_io_drive),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_read_data    (rsp_read_data),
      .rsp_time_out     (rsp_time_out)
   );

endmodule
